### rtl/rhc_pkg.sv
package rhc_pkg;

    // Pixel and result field widths.
    localparam int CHAN_W      = 8;
    localparam int CHAN_LEVELS = 1 << CHAN_W;
    localparam int HUE_W       = 16;
    localparam int SAT_W       = 16;

    // The hue dividend is t * 2^16, with t below 6 * chroma, and the divisor is 6 * chroma.
    localparam int HUE_DIV_MULT  = 6;
    localparam int HUE_NUM_W     = 11;
    localparam int HUE_SUM_W     = HUE_NUM_W + 1;
    localparam int HUE_DIV_W     = 11;
    localparam int HUE_RCP_SHIFT = 27;
    localparam int HUE_RCP_W     = 25;
    localparam int HUE_PROD_W    = HUE_NUM_W + HUE_RCP_W;
    localparam int HUE_EST_LSB   = HUE_RCP_SHIFT - HUE_W;
    localparam int HUE_REM_W     = HUE_NUM_W + HUE_W;

    // The saturation dividend is chroma * 65535 and the divisor is value.
    localparam int SAT_NUM_W     = CHAN_W + SAT_W;
    localparam int SAT_RCP_SHIFT = 24;
    localparam int SAT_RCP_W     = 25;
    localparam int SAT_PROD_W    = SAT_NUM_W + SAT_RCP_W;

    // Pipeline stage positions.
    localparam int PIPE_STAGES = 5;
    localparam int STG_CLS     = 0;
    localparam int STG_RCP     = 1;
    localparam int STG_EST     = 2;
    localparam int STG_BCK     = 3;
    localparam int STG_OUT     = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    value;
        logic [CHAN_W-1:0]    chroma;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DIV_W-1:0] hue_div;
    } cls_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    value;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [HUE_RCP_W-1:0] hue_rcp;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_RCP_W-1:0] sat_rcp;
    } rcp_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    value;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [HUE_W-1:0]     hue_est;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_W-1:0]     sat_est;
    } est_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    value;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [HUE_W-1:0]     hue_est;
        logic [HUE_REM_W-1:0] hue_back;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_W-1:0]     sat_est;
        logic [SAT_NUM_W-1:0] sat_back;
    } bck_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    // Load enables of the three quotient stages.
    typedef struct packed {
        logic est;
        logic back;
        logic fix;
    } quot_en_t;

endpackage

### rtl/rhc_if.sv
// Pixel request channel.
interface rhc_pix_if import rhc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result request channel.
interface rhc_hsv_if import rhc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

### rtl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter.
// A pixel request on the pixel channel carries 8-bit red, green and blue; a
// request on the hsv channel returns one result per pixel, in order: hue as a
// 16-bit fraction of a turn, saturation as chroma over value scaled to 65535,
// and brightness as the largest channel.  Both channels move a request on a
// clock edge where valid and ready are high.
// The pipeline has five register stages: classification, reciprocal table
// lookup, quotient estimate, back multiply, and correction into the output
// register.  A pixel accepted on the pixel channel passes through these
// registers in order before its result shows on the hsv channel, and one
// pixel can be accepted every cycle while the hsv receiver keeps ready high.
// The two divisions are done by reciprocal tables of 256 entries each and a
// one-step correction, so the throughput is set by the pipeline alone.
// When the receiver stalls, stages with a request hold it and empty stages
// keep filling, so up to five results wait inside before pixel ready drops.
// Reset clears every stage's valid bit; data registers are not reset.
module rgb_to_hsv_converter import rhc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rhc_pix_if.sink       pixel,
    rhc_hsv_if.source     hsv
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] adv;
    pix_t                   pix;
    cls_t                   cls;
    rcp_t                   rcp;
    hsv_t                   res;
    quot_en_t               quot_en;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[STG_OUT] = !valid_reg[STG_OUT] || hsv.ready;
        for (int k = STG_OUT - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next[STG_CLS] = adv[STG_CLS] ? pixel.valid : valid_reg[STG_CLS];
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pix.red   = pixel.red;
    assign pix.green = pixel.green;
    assign pix.blue  = pixel.blue;

    assign quot_en.est  = adv[STG_EST];
    assign quot_en.back = adv[STG_BCK];
    assign quot_en.fix  = adv[STG_OUT];

    rhc_classify u_classify
    (
        .clk (clk),
        .en  (adv[STG_CLS]),
        .pix (pix),
        .cls (cls)
    );

    rhc_recip u_recip
    (
        .clk (clk),
        .en  (adv[STG_RCP]),
        .cls (cls),
        .rcp (rcp)
    );

    rhc_quot u_quot
    (
        .clk (clk),
        .en  (quot_en),
        .rcp (rcp),
        .hsv (res)
    );

    // Channel outputs.
    assign pixel.ready    = adv[STG_CLS];
    assign hsv.valid      = valid_reg[STG_OUT];
    assign hsv.hue        = res.hue;
    assign hsv.saturation = res.saturation;
    assign hsv.brightness = res.brightness;

endmodule

### rtl/rhc_classify.sv
module rhc_classify import rhc_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  pix_t pix,
    output cls_t cls
);

    cls_t                 cls_reg;
    cls_t                 cls_next;
    logic [CHAN_W-1:0]    gb_max;
    logic [CHAN_W-1:0]    gb_min;
    logic [CHAN_W-1:0]    max_val;
    logic [CHAN_W-1:0]    min_val;
    logic [CHAN_W-1:0]    chroma;
    logic                 red_top;
    logic [HUE_DIV_W-1:0] div6;
    logic [HUE_SUM_W-1:0] base;
    logic [HUE_SUM_W-1:0] diff;
    logic [HUE_SUM_W-1:0] sum;

    // Largest and smallest channel, and their difference.
    always_comb
    begin
        gb_max  = (pix.green >= pix.blue) ? pix.green : pix.blue;
        gb_min  = (pix.green >= pix.blue) ? pix.blue : pix.green;
        red_top = (pix.red >= gb_max);
        max_val = red_top ? pix.red : gb_max;
        min_val = (pix.red < gb_min) ? pix.red : gb_min;
        chroma  = max_val - min_val;
        div6    = HUE_DIV_W'({chroma, 2'b00}) + HUE_DIV_W'({chroma, 1'b0});
    end

    // Hue numerator in sixths of a turn: twice the sector times chroma plus the
    // signed channel difference.  A negative value in the red sector is moved up
    // by a full turn, which leaves the wrapped quotient unchanged.
    always_comb
    begin
        priority if (red_top)
        begin
            diff = HUE_SUM_W'(pix.green) - HUE_SUM_W'(pix.blue);
            base = (pix.green >= pix.blue) ? '0 : HUE_SUM_W'(div6);
        end
        else if (pix.green >= pix.blue)
        begin
            diff = HUE_SUM_W'(pix.blue) - HUE_SUM_W'(pix.red);
            base = HUE_SUM_W'({chroma, 1'b0});
        end
        else
        begin
            diff = HUE_SUM_W'(pix.red) - HUE_SUM_W'(pix.green);
            base = HUE_SUM_W'({chroma, 2'b00});
        end
        sum = base + diff;

        cls_next.value   = max_val;
        cls_next.chroma  = chroma;
        cls_next.hue_num = sum[HUE_NUM_W-1:0];
        cls_next.hue_div = div6;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls = cls_reg;

endmodule

### rtl/rhc_recip.sv
module rhc_recip import rhc_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  cls_t cls,
    output rcp_t rcp
);

    rcp_t                 rcp_reg;
    rcp_t                 rcp_next;
    logic [HUE_RCP_W-1:0] hue_rcp_tab [CHAN_LEVELS];
    logic [SAT_RCP_W-1:0] sat_rcp_tab [CHAN_LEVELS];

    // Reciprocal tables, worked out at elaboration.  A zero divisor reads as a
    // zero reciprocal, so its quotient estimate is zero.
    assign hue_rcp_tab[0] = '0;
    assign sat_rcp_tab[0] = '0;

    for (genvar gi = 1; gi < CHAN_LEVELS; gi++)
    begin : g_tab
        localparam longint unsigned HueDiv = HUE_DIV_MULT * gi;
        localparam longint unsigned SatDiv = gi;
        localparam longint unsigned HueRcp = (64'd1 << HUE_RCP_SHIFT) / HueDiv;
        localparam longint unsigned SatRcp = (64'd1 << SAT_RCP_SHIFT) / SatDiv;

        assign hue_rcp_tab[gi] = HUE_RCP_W'(HueRcp);
        assign sat_rcp_tab[gi] = SAT_RCP_W'(SatRcp);
    end

    // Look up both reciprocals and form the saturation dividend chroma * 65535.
    always_comb
    begin
        rcp_next.value   = cls.value;
        rcp_next.hue_num = cls.hue_num;
        rcp_next.hue_div = cls.hue_div;
        rcp_next.hue_rcp = hue_rcp_tab[cls.chroma];
        rcp_next.sat_num = {cls.chroma, {SAT_W{1'b0}}} - SAT_NUM_W'(cls.chroma);
        rcp_next.sat_rcp = sat_rcp_tab[cls.value];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rcp_reg <= rcp_next;
        end
    end

    assign rcp = rcp_reg;

endmodule

### rtl/rhc_quot.sv
module rhc_quot import rhc_pkg::*;
(
    input  logic     clk,
    input  quot_en_t en,
    input  rcp_t     rcp,
    output hsv_t     hsv
);

    est_t                  est_reg;
    est_t                  est_next;
    bck_t                  bck_reg;
    bck_t                  bck_next;
    hsv_t                  hsv_reg;
    hsv_t                  hsv_next;
    logic [HUE_PROD_W-1:0] hue_prod;
    logic [SAT_PROD_W-1:0] sat_prod;
    logic [HUE_REM_W-1:0]  hue_rem;
    logic [SAT_NUM_W-1:0]  sat_rem;
    logic                  hue_inc;
    logic                  sat_inc;

    // Quotient estimate by reciprocal multiply.  The estimate is never above the
    // true quotient and at most one below it.
    always_comb
    begin
        hue_prod = HUE_PROD_W'(rcp.hue_num) * HUE_PROD_W'(rcp.hue_rcp);
        sat_prod = SAT_PROD_W'(rcp.sat_num) * SAT_PROD_W'(rcp.sat_rcp);

        est_next.value   = rcp.value;
        est_next.hue_num = rcp.hue_num;
        est_next.hue_div = rcp.hue_div;
        est_next.hue_est = hue_prod[HUE_EST_LSB +: HUE_W];
        est_next.sat_num = rcp.sat_num;
        est_next.sat_est = sat_prod[SAT_RCP_SHIFT +: SAT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.est)
        begin
            est_reg <= est_next;
        end
    end

    // Multiply the estimate back by the divisor.
    always_comb
    begin
        bck_next.value    = est_reg.value;
        bck_next.hue_num  = est_reg.hue_num;
        bck_next.hue_div  = est_reg.hue_div;
        bck_next.hue_est  = est_reg.hue_est;
        bck_next.hue_back = HUE_REM_W'(est_reg.hue_est) * HUE_REM_W'(est_reg.hue_div);
        bck_next.sat_num  = est_reg.sat_num;
        bck_next.sat_est  = est_reg.sat_est;
        bck_next.sat_back = SAT_NUM_W'(est_reg.sat_est) * SAT_NUM_W'(est_reg.value);
    end

    always_ff @(posedge clk)
    begin
        if (en.back)
        begin
            bck_reg <= bck_next;
        end
    end

    // Correction: step the estimate up by one when the remainder still holds
    // a whole divisor.  A zero divisor leaves the zero estimate as it is.
    always_comb
    begin
        hue_rem = {bck_reg.hue_num, {HUE_W{1'b0}}} - bck_reg.hue_back;
        sat_rem = bck_reg.sat_num - bck_reg.sat_back;
        hue_inc = (hue_rem >= HUE_REM_W'(bck_reg.hue_div)) && (bck_reg.hue_div != '0);
        sat_inc = (sat_rem >= SAT_NUM_W'(bck_reg.value)) && (bck_reg.value != '0);

        hsv_next.hue        = bck_reg.hue_est + HUE_W'(hue_inc);
        hsv_next.saturation = bck_reg.sat_est + SAT_W'(sat_inc);
        hsv_next.brightness = bck_reg.value;
    end

    always_ff @(posedge clk)
    begin
        if (en.fix)
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign hsv = hsv_reg;

endmodule
